>>> hw/rtl/ftsq_pkg.sv
// Package for the frame time statistics block.
// Holds field widths, rate and quality constants, and the controller/datapath command types.
package ftsq_pkg;

  localparam int TIME_W = 24;
  localparam int RATE_W = 28;
  localparam int QUAL_W = 7;
  localparam int TGT_W  = 10;

  localparam logic [RATE_W-1:0] RATE_SCALE   = RATE_W'(256000000);
  // 1e6 fps scale times 10, compared against 8*target*t and 11*target*t
  localparam logic [39:0]       LIMIT_NUM    = 40'd10000000;
  localparam logic [QUAL_W-1:0] QUAL_MIN     = 7'd10;
  localparam logic [QUAL_W-1:0] QUAL_MAX     = 7'd100;
  localparam logic [QUAL_W-1:0] QUAL_DN_STEP = 7'd10;
  localparam logic [QUAL_W-1:0] QUAL_UP_STEP = 7'd5;
  localparam logic [QUAL_W-1:0] QUAL_DN_LOW  = 7'd20;
  localparam logic [TGT_W-1:0]  TARGET_RESET = 10'd60;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_ADAPT  = 1'b1;

  typedef enum logic [1:0] {
    DIV_CUR = 2'd0,
    DIV_AVG = 2'd1,
    DIV_VAR = 2'd2
  } div_sel_t;

  typedef enum logic {
    MUL_NSQ = 1'b0,
    MUL_S2  = 1'b1
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     calc_tsq;
    logic     calc_old;
    logic     update;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     sqrt_start;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic multi;
  } sts_t;

endpackage

>>> hw/rtl/frame_time_stats_quality_stepper.sv
// Top level of the frame time statistics and quality stepper.
// Depends on ftsq_pkg, ftsq_ctrl and ftsq_dp (which holds ftsq_ram and ftsq_div).
//
//  channel  | dir | handshake            | word
//  in_      | in  | in_tvalid/in_tready  | frame_time_us
//  out_     | out | out_tvalid/out_tready| fps, average fps, jitter, quality
//  cfg_     | in  | APB, pready high     | target_fps @0x0, adaptive_enable @0x4
//
// One word at a time. The bit-serial divider, run for the current rate, the average
// rate and the variance, sets most of the time a word takes. While N <= 1 the variance
// path is skipped. Synchronous active-low reset.
// A result waiting on out_tready holds the next word in the final state.
module frame_time_stats_quality_stepper
  import ftsq_pkg::*;
#(
  parameter int WINDOW = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] frame_time_us
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [27:0] current_fps, [55:28] average_fps,
                                  // [79:56] jitter_us, [86:80] quality_level,
                                  // [87] quality_changed
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [TGT_W-1:0] target_r;
  logic             adapt_r;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;
  logic [RATE_W-1:0] o_cur, o_avg;
  logic [TIME_W-1:0] o_jit;
  logic [QUAL_W-1:0] o_qual;
  logic              o_chg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      adapt_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_TARGET: target_r <= cfg_pwdata[TGT_W-1:0];
        REG_ADAPT:  adapt_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_TARGET: cfg_prdata = {{(32-TGT_W){1'b0}}, target_r};
      REG_ADAPT:  cfg_prdata = {31'd0, adapt_r};
      default:    cfg_prdata = '0;
    endcase
  end

  ftsq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ftsq_dp #(.WINDOW(WINDOW)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_time  (in_tdata),
    .target   (target_r),
    .adapt    (adapt_r),
    .out_cur  (o_cur),
    .out_avg  (o_avg),
    .out_jit  (o_jit),
    .out_qual (o_qual),
    .out_chg  (o_chg)
  );

  assign out_tdata = {o_chg, o_qual, o_jit, o_avg, o_cur};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("block still ready after taking a word");

  a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[86:80] <= 7'd100)
    else $error("quality above 100");

  a_fps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[27:0] != 28'd0 && out_tdata[55:28] != 28'd0)
    else $error("zero frame rate reported");

  a_unchanged_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && !adapt_r |=> out_tdata[87] == 1'b0)
    else $error("quality step with adaptive mode off");

endmodule

>>> hw/rtl/ftsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module ftsq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/ftsq_div.sv
// Restoring divider, one quotient bit per cycle.
// No package dependencies; used by the datapath for all three divisions.
module ftsq_div #(
  parameter int NW = 65,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [DW:0]      shifted;

  assign shifted = {rem_r, q_r[NW-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      q_nxt    = num;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = DW'(shifted - {1'b0, den_r});
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> hw/rtl/ftsq_ctrl.sv
// Sequencer for the frame time statistics block.
// Depends on ftsq_pkg for the command and status structs.
module ftsq_ctrl
  import ftsq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE = 17'b1 << 0,
    S_RD   = 17'b1 << 1,
    S_SQR  = 17'b1 << 2,
    S_UPD  = 17'b1 << 3,
    S_CUR  = 17'b1 << 4,
    S_CURW = 17'b1 << 5,
    S_AVG  = 17'b1 << 6,
    S_AVGW = 17'b1 << 7,
    S_MN   = 17'b1 << 8,
    S_MNW  = 17'b1 << 9,
    S_MS   = 17'b1 << 10,
    S_MSW  = 17'b1 << 11,
    S_VD   = 17'b1 << 12,
    S_VDW  = 17'b1 << 13,
    S_SQ   = 17'b1 << 14,
    S_SQW  = 17'b1 << 15,
    S_DONE = 17'b1 << 16
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   out_free;

  assign out_free = !ovalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_NSQ;
    cmd.div_sel = DIV_CUR;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.calc_tsq = 1'b1;
        state_nxt    = S_SQR;
      end
      S_SQR: begin
        cmd.calc_old = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CUR;
      end
      S_CUR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CUR;
        state_nxt     = S_CURW;
      end
      S_CURW: begin
        if (sts.div_done) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_nxt     = S_AVGW;
      end
      S_AVGW: begin
        // a single entry keeps the held jitter
        if (sts.div_done) begin
          state_nxt = sts.multi ? S_MN : S_DONE;
        end
      end
      S_MN: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_NSQ;
        state_nxt     = S_MNW;
      end
      S_MNW: begin
        if (sts.mul_done) begin
          state_nxt = S_MS;
        end
      end
      S_MS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_S2;
        state_nxt     = S_MSW;
      end
      S_MSW: begin
        if (sts.mul_done) begin
          state_nxt = S_VD;
        end
      end
      S_VD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VAR;
        state_nxt     = S_VDW;
      end
      S_VDW: begin
        if (sts.div_done) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQW;
      end
      S_SQW: begin
        if (sts.sqrt_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

endmodule

>>> hw/rtl/ftsq_dp.sv
// Datapath: window RAM, running sums, serial multiplier, divider, square root, quality.
// Depends on ftsq_pkg, ftsq_ram and ftsq_div.
module ftsq_dp
  import ftsq_pkg::*;
#(
  parameter int WINDOW = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [TIME_W-1:0] in_time,
  input  logic [TGT_W-1:0]  target,
  input  logic              adapt,
  output logic [RATE_W-1:0] out_cur,
  output logic [RATE_W-1:0] out_avg,
  output logic [TIME_W-1:0] out_jit,
  output logic [QUAL_W-1:0] out_qual,
  output logic              out_chg
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int AW = $clog2(WINDOW);
  localparam int SW = TIME_W + CW;
  localparam int QW = 2 * TIME_W + CW;
  localparam int PW = QW + CW;
  localparam int VW = 2 * TIME_W;
  localparam int SQ_CW = $clog2(TIME_W);

  logic [TIME_W-1:0] t_r, old_r, rd_data;
  logic [VW-1:0]     tsq_r, oldsq_r;
  logic [CW-1:0]     n_r;
  logic [AW-1:0]     slot_r;
  logic [SW-1:0]     sum_r;
  logic [QW-1:0]     sq_r;
  logic [TGT_W+TIME_W-1:0] tt_r;
  logic              full;

  assign full = (n_r == CW'(WINDOW));

  ftsq_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW)) u_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata (t_r),
    .re    (cmd.load),
    .raddr (slot_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      slot_r <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
    end else if (cmd.update) begin
      if (full) begin
        sum_r <= sum_r - SW'(old_r) + SW'(t_r);
        sq_r  <= sq_r - QW'(oldsq_r) + QW'(tsq_r);
      end else begin
        n_r   <= n_r + 1'b1;
        sum_r <= sum_r + SW'(t_r);
        sq_r  <= sq_r + QW'(tsq_r);
      end
      slot_r <= (slot_r == AW'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= (in_time == '0) ? TIME_W'(1) : in_time;
    end
    if (cmd.calc_tsq) begin
      tsq_r <= t_r * t_r;
    end
    if (cmd.calc_old) begin
      old_r   <= rd_data;
      oldsq_r <= rd_data * rd_data;
    end
    if (cmd.update) begin
      tt_r <= target * t_r;
    end
  end

  // shift-add multiplier, stops once the multiplier bits run out
  logic [PW-1:0] ma_r, macc_r, nsq_r;
  logic [SW-1:0] mb_r;
  logic          mbusy_r, mdone_r;
  mul_sel_t      msel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
      end else if (mbusy_r && mb_r == '0) begin
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end
    end
    if (cmd.mul_start) begin
      msel_r <= cmd.mul_sel;
      macc_r <= '0;
      if (cmd.mul_sel == MUL_NSQ) begin
        ma_r <= PW'(sq_r);
        mb_r <= SW'(n_r);
      end else begin
        ma_r <= PW'(sum_r);
        mb_r <= sum_r;
      end
    end else if (mbusy_r && mb_r != '0) begin
      if (mb_r[0]) begin
        macc_r <= macc_r + ma_r;
      end
      ma_r <= {ma_r[PW-2:0], 1'b0};
      mb_r <= {1'b0, mb_r[SW-1:1]};
    end
    if (mdone_r && msel_r == MUL_NSQ) begin
      nsq_r <= macc_r;
    end
  end

  // divider operand selection
  logic [PW-1:0]   dnum;
  logic [SW-1:0]   dden;
  logic [2*CW-1:0] nn;
  logic [PW-1:0]   dquo;
  logic            ddone;
  div_sel_t        dsel_r;
  logic [RATE_W-1:0] cur_r, avg_r;
  logic [VW-1:0]   var_r;

  assign nn = {{CW{1'b0}}, n_r} * {{CW{1'b0}}, n_r};

  always_comb begin
    case (cmd.div_sel)
      DIV_CUR: begin
        dnum = PW'(RATE_SCALE);
        dden = SW'(t_r);
      end
      DIV_AVG: begin
        dnum = PW'(n_r) * PW'(RATE_SCALE);
        dden = sum_r;
      end
      DIV_VAR: begin
        dnum = nsq_r - macc_r;
        dden = SW'(nn);
      end
      default: begin
        dnum = '0;
        dden = '1;
      end
    endcase
  end

  ftsq_div #(.NW(PW), .DW(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (dden),
    .done  (ddone),
    .quo   (dquo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end
    if (ddone) begin
      case (dsel_r)
        DIV_CUR: cur_r <= dquo[RATE_W-1:0];
        DIV_AVG: avg_r <= dquo[RATE_W-1:0];
        DIV_VAR: var_r <= dquo[VW-1:0];
        default: ;
      endcase
    end
  end

  // digit-by-digit square root, two radicand bits per step
  logic [VW-1:0]     sx_r;
  logic [TIME_W+1:0] srem_r;
  logic [TIME_W-1:0] sroot_r, jit_r;
  logic [SQ_CW-1:0]  scnt_r;
  logic              sbusy_r, sdone_r;
  logic [TIME_W+3:0] srs, strial;

  assign srs    = {srem_r, sx_r[VW-1:VW-2]};
  assign strial = {2'b00, sroot_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
      sdone_r <= 1'b0;
      scnt_r  <= '0;
      jit_r   <= '0;
    end else begin
      sdone_r <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy_r <= 1'b1;
        scnt_r  <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 1'b1;
        if (scnt_r == SQ_CW'(TIME_W - 1)) begin
          sbusy_r <= 1'b0;
          sdone_r <= 1'b1;
        end
      end
      if (sdone_r) begin
        jit_r <= sroot_r;
      end
    end
    if (cmd.sqrt_start) begin
      sx_r    <= var_r;
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (sbusy_r) begin
      sx_r <= {sx_r[VW-3:0], 2'b00};
      if (srs >= strial) begin
        srem_r  <= (TIME_W + 2)'(srs - strial);
        sroot_r <= {sroot_r[TIME_W-2:0], 1'b1};
      end else begin
        srem_r  <= srs[TIME_W+1:0];
        sroot_r <= {sroot_r[TIME_W-2:0], 1'b0};
      end
    end
  end

  // quality step and result word
  logic [QUAL_W-1:0] qual_r, qual_nxt;
  logic              chg_nxt, step_dn, step_up;
  logic [39:0]       tt8, tt11;
  logic [QUAL_W-1:0] qual_up;

  assign tt8     = {3'b000, tt_r, 3'b000};
  assign tt11    = 40'(tt_r) * 40'd11;
  assign step_dn = LIMIT_NUM < tt8;
  assign step_up = LIMIT_NUM > tt11;
  assign qual_up = qual_r + QUAL_UP_STEP;

  always_comb begin
    qual_nxt = qual_r;
    chg_nxt  = 1'b0;
    if (adapt) begin
      if (step_dn) begin
        qual_nxt = (qual_r < QUAL_DN_LOW) ? QUAL_MIN : qual_r - QUAL_DN_STEP;
        chg_nxt  = 1'b1;
      end else if (step_up) begin
        qual_nxt = (qual_up > QUAL_MAX) ? QUAL_MAX : qual_up;
        chg_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qual_r <= '0;
    end else if (cmd.finish) begin
      qual_r <= qual_nxt;
    end
    if (cmd.finish) begin
      out_cur  <= cur_r;
      out_avg  <= avg_r;
      out_jit  <= jit_r;
      out_qual <= qual_nxt;
      out_chg  <= chg_nxt;
    end
  end

  assign sts.mul_done  = mdone_r;
  assign sts.div_done  = ddone;
  assign sts.sqrt_done = sdone_r;
  assign sts.multi     = (n_r > CW'(1));

endmodule

>>> sim/tb_frame_time_stats_quality_stepper.sv
// Testbench for frame_time_stats_quality_stepper: streams frame times with random
// idling on both sides, writes target and adaptive mode over APB between phases, and
// checks every word against a local model. Depends on ftsq_pkg and the block's RTL.
`timescale 1ns / 1ps

class ftsq_scoreboard;
  localparam int WIN = 60;

  typedef struct packed {
    logic [27:0] cur_fps;
    logic [27:0] avg_fps;
    logic [23:0] jitter;
    logic [6:0]  quality;
    logic        changed;
  } stats_t;

  logic [23:0]  frame_hist[WIN];
  int unsigned  fill;
  int unsigned  slot;
  logic [63:0]  sum_t;
  logic [63:0]  sum_sq;
  logic [6:0]   qual;
  logic [23:0]  hold_jit;
  logic [9:0]   target;
  logic         adapt;
  stats_t       pending[$];
  int           errors;

  function new();
    fill = 0; slot = 0; sum_t = 0; sum_sq = 0; qual = 0; hold_jit = 0;
    target = 10'd60; adapt = 1'b0; errors = 0;
  endfunction

  function logic [63:0] isqrt(logic [127:0] v);
    logic [127:0] root;
    logic [127:0] bitv;
    root = 0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  function void note_frame(logic [23:0] raw);
    logic [63:0]  t;
    logic [63:0]  tt;
    logic [127:0] num;
    logic [127:0] nn;
    stats_t       r;
    t = (raw == 0) ? 64'd1 : {40'd0, raw};
    if (fill >= WIN) begin
      sum_t  -= frame_hist[slot];
      sum_sq -= frame_hist[slot] * frame_hist[slot];
    end else begin
      fill++;
    end
    frame_hist[slot] = t[23:0];
    sum_t  += t;
    sum_sq += t * t;
    slot = (slot + 1) % WIN;
    r.changed = 1'b0;
    r.cur_fps = 28'(64'd256000000 / t);
    r.avg_fps = 28'((64'd256000000 * fill) / sum_t);
    if (fill > 1) begin
      // N*sq >= s^2 always, so the variance numerator never goes negative
      num = 128'(fill) * sum_sq - 128'(sum_t) * sum_t;
      nn  = 128'(fill) * fill;
      hold_jit = 24'(isqrt(num / nn));
    end
    if (adapt) begin
      tt = 64'(target) * t;
      if (64'd10000000 < 8 * tt) begin
        qual = (qual < 20) ? 7'd10 : qual - 7'd10;
        r.changed = 1'b1;
      end else if (64'd10000000 > 11 * tt) begin
        qual = (qual + 5 > 100) ? 7'd100 : qual + 7'd5;
        r.changed = 1'b1;
      end
    end
    r.jitter  = hold_jit;
    r.quality = qual;
    pending = {pending, r};
  endfunction

  function void check_word(logic [87:0] w);
    stats_t e;
    if (pending.size() == 0) begin
      $error("unexpected output word %h", w);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (w[27:0] !== e.cur_fps) begin
      $error("current_fps exp %0d got %0d", e.cur_fps, w[27:0]); errors++;
    end
    if (w[55:28] !== e.avg_fps) begin
      $error("average_fps exp %0d got %0d", e.avg_fps, w[55:28]); errors++;
    end
    if (w[79:56] !== e.jitter) begin
      $error("jitter_us exp %0d got %0d", e.jitter, w[79:56]); errors++;
    end
    if (w[86:80] !== e.quality) begin
      $error("quality_level exp %0d got %0d", e.quality, w[86:80]); errors++;
    end
    if (w[87] !== e.changed) begin
      $error("quality_changed exp %0d got %0d", e.changed, w[87]); errors++;
    end
  endfunction
endclass

module tb_frame_time_stats_quality_stepper;
  import ftsq_pkg::*;

  localparam logic [2:0] ADDR_TARGET = 3'h0;
  localparam logic [2:0] ADDR_ADAPT  = 3'h4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  ftsq_scoreboard stats_model = new();

  frame_time_stats_quality_stepper dut (.*);

  always #5 clk = ~clk;

  // receiver: random tready, words checked at the rising edge
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  always @(posedge clk) if (rst_n && out_tvalid && out_tready) stats_model.check_word(out_tdata);

  initial begin
    #50_000_000;
    $display("frame_time_stats_quality_stepper regression: fail");
    $finish;
  end

  // tvalid drops only while idling or draining, so each falling edge sees one update
  task automatic send_frame(input logic [23:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stats_model.note_frame(t);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (stats_model.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_TARGET) stats_model.target = val[9:0];
    else if (addr == ADDR_ADAPT) stats_model.adapt = val[0];
    @(negedge clk);
  endtask

  // mostly frame times near the target period so quality moves both ways
  function automatic logic [23:0] rand_frame();
    case ($urandom_range(9))
      0: return 24'($urandom_range(3));
      1: return 24'($urandom);
      2: return 24'($urandom_range(255));
      default: return 24'($urandom_range(40000, 5000));
    endcase
  endfunction

  initial begin
    logic [23:0] directed[11];
    directed = '{24'd0, 24'd1, 24'hFFFFFF, 24'd16667, 24'd16667, 24'd10000,
                 24'd30000, 24'd12000, 24'h800000, 24'h7FFFFF, 24'd2};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_frame(directed[i]);
    drain();
    write_reg(ADDR_ADAPT, 32'd1);
    foreach (directed[i]) send_frame(directed[i]);
    drain();
    write_reg(ADDR_TARGET, 32'd0);  // zero target: every frame steps up
    send_frame(24'd5000);
    send_frame(24'hFFFFFF);
    drain();
    write_reg(ADDR_TARGET, 32'd1023);
    send_frame(24'd1);
    send_frame(24'd20000);
    drain();
    write_reg(ADDR_TARGET, 32'd60);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
      for (int k = 0; k < 250; k++) begin
        send_frame(rand_frame());
        if (k == 100) drain();
      end
      drain();
      write_reg(ADDR_TARGET, (ph == 0) ? 32'd1 : (ph == 1) ? 32'd1000 : 32'd60);
      write_reg(ADDR_ADAPT, 32'($urandom_range(1)));
      write_reg(ADDR_TARGET, 32'($urandom_range(1, 1000)));
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    if (stats_model.errors == 0 && stats_model.pending.size() == 0)
      $display("frame_time_stats_quality_stepper regression: pass");
    else
      $display("frame_time_stats_quality_stepper regression: fail");
    $finish;
  end
endmodule
